// File: rtl/core/slam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slam_pkg
// Types and constants shared by the sound level alarm monitor.
// ----------------------------------------------------------------------------
package slam_pkg;

  localparam int unsigned SampleBits = 10;
  localparam int unsigned AmpW       = SampleBits + 1;
  localparam int unsigned LevelW     = 7;
  localparam int unsigned RedW       = 11;
  localparam int unsigned GreenW     = 10;
  localparam int unsigned CountW     = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;

  localparam int unsigned FullScale  = 1 << SampleBits;
  localparam int unsigned DbLow      = 40;
  localparam int unsigned DbSpan     = 110 - 40;
  localparam int unsigned PwmTop     = 1024;
  localparam int unsigned PwmShift   = 10;
  localparam int unsigned PwmFloor   = 100;
  localparam int unsigned PwmSpan    = 1024 - 100;
  localparam int unsigned GreenTop   = 1023;

  localparam int unsigned LevelProdW = AmpW + 7;
  localparam int unsigned DutyProdW  = RedW + 10;

  localparam logic [LevelW-1:0] DangerLevelRst = LevelW'(85);
  localparam logic [CountW-1:0] DangerCountRst = CountW'(100);
  localparam logic [CountW-1:0] BlinkPeriodRst = CountW'(10);

  typedef enum logic [CfgIdxW-1:0] {
    CfgDangerLevel = 2'd0,
    CfgDangerCount = 2'd1,
    CfgBlinkPeriod = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FuncSample    = 2'd0,
    FuncWindowEnd = 2'd1,
    FuncBlinkTick = 2'd2
  } func_e;

  typedef enum logic {
    KindWindow = 1'b0,
    KindBlink  = 1'b1
  } kind_e;

  typedef struct packed {
    func_e                 func;
    logic [SampleBits-1:0] sample_value;
  } in_word_t;

  typedef struct packed {
    kind_e             result_kind;
    logic [AmpW-1:0]   amplitude;
    logic [LevelW-1:0] level_db;
    logic              display_update;
    logic [RedW-1:0]   red_duty;
    logic [GreenW-1:0] green_duty;
    logic              danger_alert;
    logic              blinking;
    logic              leds_enabled;
  } out_word_t;

endpackage
`default_nettype wire

// File: rtl/core/sound_level_alarm_monitor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sound_level_alarm_monitor_core
// Window peak-to-peak tracker with dB estimate, LED duties and danger alarm.
// ----------------------------------------------------------------------------
// One word is accepted per clock. Samples update the window min/max and give
// no result; a window-end or blink-tick word gives one result word, registered
// in the output or the skid register. A two-entry output queue (output
// register plus skid register) lets input flow on while a result waits; input
// stalls only when both entries are full. All arithmetic (min/max compare,
// constant scaling for level and duties) is done in the acceptance cycle.
module sound_level_alarm_monitor_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [slam_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [slam_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire slam_pkg::in_word_t           in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output slam_pkg::out_word_t               out_data_o
);
  import slam_pkg::*;

  logic [LevelW-1:0]     danger_level_q;
  logic [CountW-1:0]     danger_count_q;
  logic [CountW-1:0]     blink_period_q;

  logic [SampleBits-1:0] win_max_q, win_max_d;
  logic [AmpW-1:0]       win_min_q, win_min_d;
  logic [LevelW-1:0]     shown_level_q, shown_level_d;
  logic [CountW-1:0]     loud_count_q, loud_count_d;
  logic                  blink_mode_q, blink_mode_d;
  logic                  toggle_phase_q, toggle_phase_d;
  logic [CountW-1:0]     tick_count_q, tick_count_d;
  logic                  channel_on_q, channel_on_d;
  logic [RedW-1:0]       red_hold_q, red_hold_d;
  logic [GreenW-1:0]     green_hold_q, green_hold_d;

  out_word_t             out_q, skid_q, res_w;
  logic                  out_valid_q, skid_valid_q;
  logic                  in_fire, out_fire, push;

  logic [AmpW-1:0]       amp;
  logic [LevelProdW-1:0] level_prod;
  logic [LevelW-1:0]     level;
  logic [RedW-1:0]       red_in;
  logic [DutyProdW-1:0]  red_prod, green_prod;
  logic [RedW-1:0]       red_val;
  logic [GreenW-1:0]     green_val;
  logic [CountW-1:0]     loud_inc, tick_inc;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_fire    = out_valid_q && out_ready_i;

  // window arithmetic
  assign amp = ({1'b0, win_max_q} >= win_min_q) ? ({1'b0, win_max_q} - win_min_q)
                                                : (win_min_q - {1'b0, win_max_q});
  assign level_prod = LevelProdW'(amp) * LevelProdW'(DbSpan);
  assign level      = LevelW'(level_prod >> SampleBits) + LevelW'(DbLow);
  assign red_in     = (DutyProdW'(amp) > DutyProdW'(PwmTop)) ? RedW'(PwmTop) : RedW'(amp);
  assign red_prod   = DutyProdW'(red_in) * DutyProdW'(PwmSpan);
  assign red_val    = RedW'(red_prod >> PwmShift) + RedW'(PwmFloor);
  assign green_prod = DutyProdW'(RedW'(GreenTop) - RedW'(amp)) * DutyProdW'(PwmSpan);
  assign green_val  = (DutyProdW'(amp) >= DutyProdW'(GreenTop)) ? GreenW'(PwmFloor)
                      : GreenW'(green_prod >> PwmShift) + GreenW'(PwmFloor);
  assign loud_inc   = loud_count_q + CountW'(1);
  assign tick_inc   = tick_count_q + CountW'(1);

  always_comb begin
    win_max_d      = win_max_q;
    win_min_d      = win_min_q;
    shown_level_d  = shown_level_q;
    loud_count_d   = loud_count_q;
    blink_mode_d   = blink_mode_q;
    toggle_phase_d = toggle_phase_q;
    tick_count_d   = tick_count_q;
    channel_on_d   = channel_on_q;
    red_hold_d     = red_hold_q;
    green_hold_d   = green_hold_q;
    push           = 1'b0;
    res_w          = '0;
    unique case (in_data_i.func)
      FuncSample: begin
        if (in_data_i.sample_value > win_max_q) begin
          win_max_d = in_data_i.sample_value;
        end
        if ({1'b0, in_data_i.sample_value} < win_min_q) begin
          win_min_d = {1'b0, in_data_i.sample_value};
        end
      end
      FuncWindowEnd: begin
        push                 = 1'b1;
        res_w.result_kind    = KindWindow;
        res_w.amplitude      = amp;
        res_w.level_db       = level;
        if (level != shown_level_q) begin
          shown_level_d        = level;
          res_w.display_update = 1'b1;
          red_hold_d           = red_val;
          green_hold_d         = green_val;
        end
        if (level > danger_level_q) begin
          loud_count_d = loud_inc;
          if (loud_inc == danger_count_q) begin
            blink_mode_d       = 1'b1;
            res_w.danger_alert = 1'b1;
            loud_count_d       = '0;
          end
        end else begin
          loud_count_d = '0;
          blink_mode_d = 1'b0;
        end
        win_max_d = '0;
        win_min_d = AmpW'(FullScale);
      end
      FuncBlinkTick: begin
        push              = 1'b1;
        res_w.result_kind = KindBlink;
        res_w.level_db    = shown_level_q;
        if (blink_mode_q) begin
          tick_count_d = tick_inc;
          if (tick_inc == blink_period_q) begin
            channel_on_d   = !toggle_phase_q;
            toggle_phase_d = !toggle_phase_q;
            tick_count_d   = '0;
          end
        end else begin
          channel_on_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res_w.red_duty     = red_hold_d;
    res_w.green_duty   = green_hold_d;
    res_w.blinking     = blink_mode_d;
    res_w.leds_enabled = channel_on_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      danger_level_q <= DangerLevelRst;
      danger_count_q <= DangerCountRst;
      blink_period_q <= BlinkPeriodRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDangerLevel: danger_level_q <= LevelW'(cfg_data_i);
        CfgDangerCount: danger_count_q <= cfg_data_i;
        CfgBlinkPeriod: blink_period_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_max_q      <= '0;
      win_min_q      <= AmpW'(FullScale);
      shown_level_q  <= '0;
      loud_count_q   <= '0;
      blink_mode_q   <= 1'b0;
      toggle_phase_q <= 1'b0;
      tick_count_q   <= '0;
      channel_on_q   <= 1'b1;
      red_hold_q     <= RedW'(GreenTop);
      green_hold_q   <= GreenW'(GreenTop);
    end else if (in_fire) begin
      win_max_q      <= win_max_d;
      win_min_q      <= win_min_d;
      shown_level_q  <= shown_level_d;
      loud_count_q   <= loud_count_d;
      blink_mode_q   <= blink_mode_d;
      toggle_phase_q <= toggle_phase_d;
      tick_count_q   <= tick_count_d;
      channel_on_q   <= channel_on_d;
      red_hold_q     <= red_hold_d;
      green_hold_q   <= green_hold_d;
    end
  end

  // two-entry result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_fire) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_fire && push;
        end
      end else if (!out_valid_q) begin
        out_valid_q <= in_fire && push;
      end else if (in_fire && push) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire && skid_valid_q) begin
      out_q <= skid_q;
    end else if ((out_fire || !out_valid_q) && in_fire && push) begin
      out_q <= res_w;
    end else if (out_valid_q && !out_fire && in_fire && push) begin
      skid_q <= res_w;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output entry");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.func == FuncWindowEnd || in_data_i.func == FuncBlinkTick))
    |=> out_valid_o)
    else $error("result word missing after window end or blink tick");

  a_blink_clear_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(blink_mode_q) |-> $past(in_fire && in_data_i.func == FuncWindowEnd))
    else $error("blink mode cleared outside a window end");

  a_green_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.green_duty >= GreenW'(PwmFloor)))
    else $error("green duty below floor");
`endif

endmodule
`default_nettype wire
